@@ rtl/spq_pkg.sv @@
// shared types, constants and helper functions of the sorted priority event queue
package spq_pkg;

	localparam int QUEUE_DEPTH   = 32;
	localparam int PAYLOAD_BITS  = 64;
	localparam int PRIORITY_BITS = 3;

	localparam int IDX_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W     = 8;
	localparam int TS_W     = 32;
	localparam int LIMIT_W  = 9;
	localparam int ACT_W    = 2;
	localparam int NBYTES_W = 4;
	localparam int STATUS_W = 2;

	localparam logic [ACT_W-1:0] ACT_POST  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic [ID_W-1:0]          ev_id;
		logic [PRIORITY_BITS-1:0] priority_req;
		logic [TS_W-1:0]          timestamp;
		logic [PAYLOAD_BITS-1:0]  payload;
		logic [NBYTES_W-1:0]      payload_bytes;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [ID_W-1:0]          out_ev_id;
		logic [PRIORITY_BITS-1:0] out_priority;
		logic [TS_W-1:0]          out_timestamp;
		logic [PAYLOAD_BITS-1:0]  out_payload;
		logic [CNT_W-1:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]          ident;
		logic [PRIORITY_BITS-1:0] prio;
		logic [TS_W-1:0]          ts;
		logic [PAYLOAD_BITS-1:0]  data;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// ring position of an offset from the head, sum stays below twice the depth
	function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] head,
			logic [CNT_W-1:0] offset);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	// zero every payload bit at or above eight times the given byte count
	function automatic logic [PAYLOAD_BITS-1:0] keep_bytes(logic [PAYLOAD_BITS-1:0] value,
			logic [NBYTES_W-1:0] nbytes);
		logic [PAYLOAD_BITS-1:0] result;
		logic [NBYTES_W+2:0]     nbits;
		nbits = {nbytes, 3'b000};
		for (int i = 0; i < PAYLOAD_BITS; i++) begin
			result[i] = value[i] && (i < int'(nbits));
		end
		return result;
	endfunction

endpackage

@@ rtl/spq_if.sv @@
// valid/ready channel interfaces of the sorted priority event queue
interface spq_req_if;
	logic          valid;
	logic          ready;
	spq_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
	logic          valid;
	logic          ready;
	spq_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spq_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [spq_pkg::LIMIT_W-1:0]  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/spq_ram.sv @@
// generic simple dual-port ram with registered read
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sorted_priority_event_queue.sv @@
// top level: sorted insertion priority queue with one shared compare unit
//
//  channel | dir | payload                                          | transaction
//  req     | in  | action, ev_id, priority_req, timestamp,          | valid && ready
//          |     | payload, payload_bytes                           |
//  rsp     | out | status, out_ev_id, out_priority,                 | valid && ready
//          |     | out_timestamp, out_payload, occupancy            |
//  cfg     | in  | id limit                                         | valid && ready
//
// pop, flush, rejected post, unused action: done follows the accept, then the result is loaded
// accepted post: the scan moves n entries back one slot (up to 31), then place or done;
// an empty queue goes straight to place; one ram read, compare and write per moved entry
// ready is low from accept until the result is loaded; a stalled rsp holds the block
// in its last step, the result register then frees req for the next transaction
// reset clears head, count and state at once; no clearing pass, the limit goes to 256
module sorted_priority_event_queue (
	input  logic          clk,
	input  logic          arst_n,
	spq_req_if.sink       req,
	spq_rsp_if.source     rsp,
	spq_cfg_if.sink       cfg
);

	import spq_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_PLACE = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    j_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [STATUS_W-1:0] status_q;
	logic                pop_q;
	entry_t              new_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic                accept;
	logic                id_bad;
	logic                full;
	logic                empty;
	logic                out_free;
	logic                goes_after;
	logic [STATUS_W-1:0] status_d;
	entry_t              new_entry;
	entry_t              rentry;
	logic [CNT_W-1:0]    j_m1;
	logic [CNT_W-1:0]    j_m2;
	logic [CNT_W-1:0]    cnt_m1;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	spq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign out_free  = !out_valid_q || rsp.ready;

	assign id_bad = {1'b0, req.data.ev_id} >= limit_q;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign j_m1   = j_q - CNT_W'(1);
	assign j_m2   = j_q - CNT_W'(2);
	assign cnt_m1 = count_q - CNT_W'(1);

	always_comb begin
		new_entry.ident = req.data.ev_id;
		new_entry.prio  = req.data.priority_req;
		new_entry.ts    = req.data.timestamp;
		new_entry.data  = keep_bytes(req.data.payload, req.data.payload_bytes);
	end

	always_comb begin
		status_d = ST_OK;
		case (req.data.action)
			ACT_POST: begin
				if (id_bad) begin
					status_d = ST_BAD_ID;
				end else if (full) begin
					status_d = ST_FULL;
				end
			end
			ACT_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	assign rentry = entry_t'(ram_rdata);

	// stored entry ranks strictly behind the new one: it moves back a slot
	assign goes_after = (rentry.prio < new_q.prio) ||
		((rentry.prio == new_q.prio) && (rentry.ts > new_q.ts));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_of(head_q, j_q);
		ram_wdata = new_q;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.data.action == ACT_POP && !empty) begin
					ram_re = 1'b1;
				end
				if (accept && req.data.action == ACT_POST && !id_bad && !full && !empty) begin
					ram_re    = 1'b1;
					ram_raddr = slot_of(head_q, cnt_m1);
				end
			end
			S_SCAN: begin
				ram_we = 1'b1;
				if (goes_after) begin
					ram_wdata = rentry;
					if (j_q != CNT_W'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = slot_of(head_q, j_m2);
					end
				end
			end
			S_PLACE: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.data.action == ACT_POST && !id_bad && !full) begin
							state_q <= empty ? S_PLACE : S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
						case (req.data.action)
							ACT_POST: begin
								if (!id_bad && !full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_POP: begin
								if (!empty) begin
									head_q  <= slot_of(head_q, CNT_W'(1));
									count_q <= cnt_m1;
								end
							end
							ACT_FLUSH: begin
								head_q  <= '0;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!goes_after) begin
						state_q <= S_DONE;
					end else if (j_q == CNT_W'(1)) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q    <= new_entry;
			j_q      <= count_q;
			pop_q    <= (req.data.action == ACT_POP) && !empty;
			status_q <= status_d;
		end
		if (state_q == S_SCAN && goes_after) begin
			j_q <= j_m1;
		end
		// popped entry stays in the ram read register, no read is issued in done
		if (state_q == S_DONE && out_free) begin
			out_q.status        <= status_q;
			out_q.out_ev_id     <= pop_q ? rentry.ident : '0;
			out_q.out_priority  <= pop_q ? rentry.prio : '0;
			out_q.out_timestamp <= pop_q ? rentry.ts : '0;
			out_q.out_payload   <= pop_q ? rentry.data : '0;
			out_q.occupancy     <= count_q;
		end
	end

endmodule

@@ rtl/spq_checker.sv @@
// port-level checks of the sorted priority event queue and their bind
module spq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input spq_pkg::rsp_t rsp_data
);

	import spq_pkg::*;

	// one transaction at a time: the block is busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req accepted while previous transaction in progress");

	a_occupancy_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.occupancy <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_EMPTY |->
			rsp_data.occupancy == '0 && rsp_data.out_ev_id == '0 &&
			rsp_data.out_payload == '0)
		else $error("empty status with entries or data");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_FULL |->
			rsp_data.occupancy == CNT_W'(QUEUE_DEPTH) && rsp_data.out_timestamp == '0)
		else $error("full status with free slots or data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled rsp dropped or changed");

endmodule

bind sorted_priority_event_queue spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
